// ----- design/zero_minor_check_mod_p_top_defines.svh -----
// Assertion macros for the zero-minor checker.
`ifndef ZERO_MINOR_CHECK_MOD_P_TOP_DEFINES_SVH
`define ZERO_MINOR_CHECK_MOD_P_TOP_DEFINES_SVH

// Check a property outside reset.
`define ZMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check a property at every edge, reset included.
`define ZMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ----- design/zmc_pkg.sv -----
// Shared constants for the zero-minor modulus check.
package zmc_pkg;

  localparam int EntryW = 16;
  localparam int ProdW  = 2 * EntryW;
  localparam int MagW   = 2 * EntryW;
  localparam int ModW   = 16;
  localparam logic [ModW-1:0] ModReset = ModW'(2);
  localparam int NumPairs = 3;
  localparam int NumEntries = 9;
  localparam int InDataW = NumEntries * EntryW;
  localparam int OutDataW = 8;

  localparam int PairLo [NumPairs] = '{0, 0, 1};
  localparam int PairHi [NumPairs] = '{1, 2, 2};

endpackage

// ----- design/zmc_mod_lane.sv -----
// Bit-serial restoring remainder pipeline testing one minor magnitude for zero mod p.
module zmc_mod_lane (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [zmc_pkg::MagW-1:0]    num_i,
  input  logic [zmc_pkg::ModW-1:0]    mod_i,
  output logic                        zero_o
);

  localparam int MW = zmc_pkg::MagW;
  localparam int PW = zmc_pkg::ModW;

  logic [PW-1:0] rem_q [MW];
  logic [MW-1:0] num_q [MW];
  logic [PW-1:0] mod_q [MW];
  logic          nz_q  [MW];

  for (genvar k = 0; k < MW; k++) begin : g_step
    logic [PW-1:0] rem_p;
    logic [PW-1:0] mod_p;
    logic [MW-1:0] num_p;
    logic          nz_p;
    logic [PW:0]   trial;
    logic [PW:0]   diff;

    if (k == 0) begin : g_first
      assign rem_p = '0;
      assign mod_p = mod_i;
      assign num_p = num_i;
      assign nz_p  = |num_i;
    end else begin : g_next
      assign rem_p = rem_q[k-1];
      assign mod_p = mod_q[k-1];
      assign num_p = num_q[k-1];
      assign nz_p  = nz_q[k-1];
    end

    assign trial = {rem_p, num_p[MW-1]};
    assign diff  = trial - {1'b0, mod_p};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= (trial >= {1'b0, mod_p}) ? diff[PW-1:0] : trial[PW-1:0];
        num_q[k] <= {num_p[MW-2:0], 1'b0};
        mod_q[k] <= mod_p;
        nz_q[k]  <= nz_p;
      end
    end
  end

  assign zero_o = (mod_q[MW-1] == '0) ? !nz_q[MW-1] : (rem_q[MW-1] == '0);

endmodule

// ----- design/zero_minor_check_mod_p_top.sv -----
// From request accept to result the data passes products, magnitude, 32 remainder steps and output.
// Throughput: one matrix per cycle; the whole pipeline holds while the output stalls.
// The remainder is formed one dividend bit per stage, which sets the depth.
// Reset clears all valid bits and sets the modulus to 2; payload is not reset.
// Top level: nine 2x2 minors of a 3x3 matrix tested for zero modulo p.
module zero_minor_check_mod_p_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [zmc_pkg::ModW-1:0]        cfg_wdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // e00, e01, e02, e10, e11, e12, e20, e21, e22 (16 bits each)
  input  logic [zmc_pkg::InDataW-1:0]     s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // zero_minor_found, then 7 zero bits
  output logic [zmc_pkg::OutDataW-1:0]    m_axis_tdata_o
);

  localparam int EW = zmc_pkg::EntryW;
  localparam int PW = zmc_pkg::ProdW;
  localparam int MW = zmc_pkg::MagW;
  localparam int NP = zmc_pkg::NumPairs;

  logic                      adv;
  logic [zmc_pkg::ModW-1:0]  modulus_q;
  logic                      prod_vld_q;
  logic                      mag_vld_q;
  logic [MW-1:0]             lane_vld_q;
  logic                      out_vld_q;
  logic                      out_zero_q;
  logic [zmc_pkg::ModW-1:0]  prod_mod_q;
  logic [zmc_pkg::ModW-1:0]  mag_mod_q;
  logic signed [PW-1:0]      pad_q [NP][NP];
  logic signed [PW-1:0]      pbc_q [NP][NP];
  logic [MW-1:0]             mag_q [NP][NP];
  logic [NP*NP-1:0]          lane_zero;
  logic signed [EW-1:0]      ent [3][3];

  assign adv = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      assign ent[r][c] = $signed(s_axis_tdata_i[(r*3+c)*EW +: EW]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= zmc_pkg::ModReset;
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      mag_vld_q  <= 1'b0;
      lane_vld_q <= '0;
      out_vld_q  <= 1'b0;
    end else if (adv) begin
      prod_vld_q <= s_axis_tvalid_i;
      mag_vld_q  <= prod_vld_q;
      lane_vld_q <= {lane_vld_q[MW-2:0], mag_vld_q};
      out_vld_q  <= lane_vld_q[MW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_mod_q <= modulus_q;
      mag_mod_q  <= prod_mod_q;
      out_zero_q <= |lane_zero;
    end
  end

  for (genvar i = 0; i < NP; i++) begin : g_rp
    for (genvar j = 0; j < NP; j++) begin : g_cp
      logic signed [PW:0] minor;

      always_ff @(posedge clk_i) begin
        if (adv) begin
          pad_q[i][j] <= PW'(ent[zmc_pkg::PairLo[i]][zmc_pkg::PairLo[j]]
                           * ent[zmc_pkg::PairHi[i]][zmc_pkg::PairHi[j]]);
          pbc_q[i][j] <= PW'(ent[zmc_pkg::PairLo[i]][zmc_pkg::PairHi[j]]
                           * ent[zmc_pkg::PairHi[i]][zmc_pkg::PairLo[j]]);
        end
      end

      assign minor = (PW+1)'(pad_q[i][j]) - (PW+1)'(pbc_q[i][j]);

      always_ff @(posedge clk_i) begin
        if (adv) begin
          mag_q[i][j] <= minor[PW] ? MW'(-minor) : MW'(minor);
        end
      end

      zmc_mod_lane u_lane (
        .clk_i  (clk_i),
        .en_i   (adv),
        .num_i  (mag_q[i][j]),
        .mod_i  (mag_mod_q),
        .zero_o (lane_zero[i*NP+j])
      );
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(zmc_pkg::OutDataW-1){1'b0}}, out_zero_q};

endmodule

// ----- design/zmc_checker.sv -----
// Port-level assertions for the zero-minor check, bound to the top level.
`include "zero_minor_check_mod_p_top_defines.svh"

module zmc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [zmc_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  `ZMC_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "result request dropped under stall")
  `ZMC_ASSERT(a_out_stable, m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o), "result changed under stall")
  `ZMC_ASSERT_ALWAYS(a_ready_empty, !m_axis_tvalid_o || m_axis_tready_i |-> s_axis_tready_o, "input held while output free")
  `ZMC_ASSERT(a_pad_zero, m_axis_tvalid_o |-> m_axis_tdata_o[7:1] == 7'd0, "result padding not zero")

endmodule

bind zero_minor_check_mod_p_top zmc_checker u_zmc_checker (.*);
